/* rtl/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// types and codes shared by the software timer table and its checker
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam logic [2:0] REQ_START        = 3'd0;
   localparam logic [2:0] REQ_START_RELOAD = 3'd1;
   localparam logic [2:0] REQ_STOP         = 3'd2;
   localparam logic [2:0] REQ_GET          = 3'd3;
   localparam logic [2:0] REQ_TICK         = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  task_id;
      logic [7:0]  event_id;
      logic [15:0] amount;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] remaining;
      logic        fired;
      logic [7:0]  fired_task;
      logic [7:0]  fired_event;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [7:0]  event_id;
      logic [15:0] remaining;
      logic [15:0] reload;
   } entry_type;

endpackage

/* rtl/software_timer_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table
// insertion-ordered table of software timers held in one synchronous memory
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request word (start, start reload, stop, get
//   timeout, tick). rsp channel returns one word per request, or for a tick
//   one word per expiry and then a closing word with last set.
//   The table lives in a single-port-write, one-read memory with a
//   registered read. A request walks the used entries one per cycle while
//   the output is not stalled: the search or tick pass reads entry i while
//   the previous read result is examined.
//   A tick compacts the table in place: survivors are written back at a
//   write pointer that never passes the read pointer.
//   One request is in work at a time; req_stall stays high until its last
//   response word has been loaded into the output register.
//   A stalled response holds in the output register and the pass waits.
//   Reset clears the used count and the control state; memory contents
//   need no clearing since only entries below the used count are read.
// ----------------------------------------------------------------------------
module software_timer_table
   import stt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   entry_type   mem [SLOTS];
   entry_type   rd_data_ff;

   logic [1:0]   state_ff, state_in;
   req_word_type req_ff, req_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] rd_ff, rd_in;      // next address to read
   logic [CW-1:0] chk_ff, chk_in;    // index of entry in rd_data_ff
   logic          chk_vld_ff, chk_vld_in;
   logic [CW-1:0] wr_ff, wr_in;      // compaction pointer
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic          rd_en;
   logic          we;
   logic [AW-1:0] wa;
   entry_type     wd;

   logic          out_free;
   logic          is_tick;
   logic          hit;
   logic [15:0]   dec;
   logic          do_fire;
   logic          keep;
   entry_type     kept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_tick  = (req_ff.req_type == REQ_TICK);
   assign hit = (rd_data_ff.task_id == req_ff.task_id)
             && (rd_data_ff.event_id == req_ff.event_id);
   assign dec = (rd_data_ff.remaining <= req_ff.amount) ? 16'd0
              : rd_data_ff.remaining - req_ff.amount;
   assign do_fire = (dec == 16'd0) && (rd_data_ff.event_id != 8'd0);
   assign keep = (rd_data_ff.event_id != 8'd0)
              && ((dec != 16'd0) || (rd_data_ff.reload != 16'd0));

   always_comb begin
      kept = rd_data_ff;
      kept.remaining = (dec == 16'd0) ? rd_data_ff.reload : dec;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      used_in      = used_ff;
      rd_in        = rd_ff;
      chk_in       = chk_ff;
      chk_vld_in   = 1'b0;
      wr_in        = wr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      we           = 1'b0;
      wa           = '0;
      wd           = rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_word;
               rd_in   = '0;
               wr_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               // examine entry held in rd_data_ff from the previous read
               if (chk_vld_ff) begin
                  if (is_tick) begin
                     if (do_fire) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{STAT_OK, 16'd0, 1'b1, rd_data_ff.task_id,
                                   rd_data_ff.event_id, 1'b0};
                     end
                     if (keep) begin
                        we    = 1'b1;
                        wa    = wr_ff[AW-1:0];
                        wd    = kept;
                        wr_in = wr_ff + 1'b1;
                     end
                  end else if (hit) begin
                     state_in = ST_DONE;
                  end
               end
               if (state_in == ST_SCAN) begin
                  if (rd_ff < used_ff) begin
                     rd_en      = 1'b1;
                     chk_in     = rd_ff;
                     chk_vld_in = 1'b1;
                     rd_in      = rd_ff + 1'b1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               if (state_in == ST_DONE) chk_vld_in = chk_vld_ff && hit && !is_tick;
               else                     chk_vld_in = chk_vld_in;
            end else begin
               chk_vld_in = chk_vld_ff;
            end
         end
         ST_DONE: begin
            chk_vld_in = chk_vld_ff;
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{STAT_OK, 16'd0, 1'b0, 8'd0, 8'd0, 1'b1};
               case (req_ff.req_type) inside
                  REQ_START, REQ_START_RELOAD: begin
                     if (chk_vld_ff) begin
                        we = 1'b1;
                        wa = chk_ff[AW-1:0];
                        wd = rd_data_ff;
                        wd.remaining = req_ff.amount;
                        if (req_ff.req_type == REQ_START_RELOAD)
                           wd.reload = req_ff.amount;
                     end else if (used_ff < SLOTS_C) begin
                        we = 1'b1;
                        wa = used_ff[AW-1:0];
                        wd = '{req_ff.task_id, req_ff.event_id, req_ff.amount,
                               (req_ff.req_type == REQ_START_RELOAD)
                                  ? req_ff.amount : 16'd0};
                        used_in = used_ff + 1'b1;
                     end else begin
                        rsp_in.status = STAT_NO_SLOT;
                     end
                  end
                  REQ_STOP: begin
                     if (chk_vld_ff) begin
                        we = 1'b1;
                        wa = chk_ff[AW-1:0];
                        wd = rd_data_ff;
                        wd.event_id = 8'd0;
                     end else rsp_in.status = STAT_NOT_FOUND;
                  end
                  REQ_GET: begin
                     if (chk_vld_ff) rsp_in.remaining = rd_data_ff.remaining;
                     else            rsp_in.status = STAT_NOT_FOUND;
                  end
                  REQ_TICK: used_in = wr_ff;
                  default: ;
               endcase
               chk_vld_in = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) rd_data_ff <= mem[rd_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rd_ff  <= rd_in;
      chk_ff <= chk_in;
      wr_ff  <= wr_in;
      rsp_ff <= rsp_in;
   end

endmodule

/* rtl/stt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_checker
// port-level checks for the software timer table
// ----------------------------------------------------------------------------
module stt_checker
   import stt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed under stall");

   // only the closing word reports a non-ok status; every other word is an expiry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> rsp_word.fired && rsp_word.status == STAT_OK)
      else $error("non-last word without expiry");

   // a fired word never has last set and names a nonzero event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.fired |-> !rsp_word.last && rsp_word.fired_event != 8'd0)
      else $error("bad expiry word");

   // the block is busy right after accepting a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
